// ===== rtl/core/pktd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pktd_pkg
// Shared types, sizes and codes of the pulse top-k energy detector.
// ----------------------------------------------------------------------------
package pktd_pkg;

  localparam int PULSE_DEPTH = 256;
  localparam int TOP_DEPTH   = 16;
  localparam int SAMPLE_BITS = 12;

  localparam int ADDR_W = $clog2(PULSE_DEPTH);
  localparam int PTR_W  = ADDR_W + 1;
  localparam int TOP_W  = $clog2(TOP_DEPTH + 1);
  localparam int TIDX_W = (TOP_DEPTH > 1) ? $clog2(TOP_DEPTH) : 1;
  localparam int ACC_W  = SAMPLE_BITS + TOP_W;
  localparam int DSTP_W = $clog2(ACC_W);

  // Input commands
  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_START  = 2'd1,
    CMD_ABORT  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  // Capture modes, also reported as capture_status
  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_CAPTURE  = 2'd1,
    MODE_FINISHED = 2'd2
  } mode_t;

  // Register indexes
  localparam logic [1:0] REG_THRESHOLD   = 2'd0;
  localparam logic [1:0] REG_PICK_COUNT  = 2'd1;
  localparam logic [1:0] REG_QUIET_LIMIT = 2'd2;

  localparam logic [11:0] THRESHOLD_RST   = 12'd2048;
  localparam logic [4:0]  PICK_COUNT_RST  = 5'd16;
  localparam logic [7:0]  QUIET_LIMIT_RST = 8'd10;

  localparam logic KIND_PULSE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic step;
    logic ld_read;
    logic walk;
    logic sum;
    logic div_init;
    logic div_step;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic res_now;
    logic res_read;
    logic fin;
    logic walk_done;
    logic sum_last;
    logic div_last;
  } dp_status_t;

endpackage

// ===== rtl/core/pktd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pktd_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface pktd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [11:0] sample;

  modport source (output valid, cmd, sample, input ready);
  modport sink   (input valid, cmd, sample, output ready);
endinterface

interface pktd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [11:0] energy;
  logic [31:0] pulse_total;
  logic [7:0]  entry_index;
  logic [1:0]  capture_status;

  modport source (output valid, kind, energy, pulse_total, entry_index, capture_status,
                  input ready);
  modport sink   (input valid, kind, energy, pulse_total, entry_index, capture_status,
                  output ready);
endinterface

// ===== rtl/core/pulse_top_k_energy_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_top_k_energy_detector
// Pulse detector averaging the largest samples of each pulse; raw capture.
// ----------------------------------------------------------------------------
// A sample, start, abort or non-finished read word is handled on acceptance; a
// read of a finished capture waits for the registered store read. The word
// that ends a pulse walks the n buffered samples through the single store read
// port into the top list, sums the list, and runs the bit-serial divider,
// before the result word appears. A new word is taken only once the previous
// result word has been accepted. Configuration is written on cfg_write with
// cfg_index/cfg_data.
module pulse_top_k_energy_detector import pktd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  pktd_in_if.sink     in_ch,
  pktd_out_if.source  out_ch,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  pktd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  pktd_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .in_cmd         (in_ch.cmd),
    .in_sample      (in_ch.sample),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .kind           (out_ch.kind),
    .energy         (out_ch.energy),
    .pulse_total    (out_ch.pulse_total),
    .entry_index    (out_ch.entry_index),
    .capture_status (out_ch.capture_status)
  );

endmodule

// ===== rtl/core/pktd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pktd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pktd_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/pktd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pktd_datapath
// Detector state, sample store, top list, summing and divider.
// ----------------------------------------------------------------------------
module pktd_datapath import pktd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  status,
  input  logic [1:0]  in_cmd,
  input  logic [11:0] in_sample,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  output logic        kind,
  output logic [11:0] energy,
  output logic [31:0] pulse_total,
  output logic [7:0]  entry_index,
  output logic [1:0]  capture_status
);

  // configuration
  logic [11:0] threshold;
  logic [4:0]  pick_count;
  logic [7:0]  quiet_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold   <= THRESHOLD_RST;
      pick_count  <= PICK_COUNT_RST;
      quiet_limit <= QUIET_LIMIT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_THRESHOLD:   threshold   <= cfg_data;
        REG_PICK_COUNT:  pick_count  <= cfg_data[4:0];
        REG_QUIET_LIMIT: quiet_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // state
  mode_t                   mode;
  logic                    pulse_act;
  logic [PTR_W-1:0]        fill;
  logic [7:0]              quiet;
  logic [31:0]             total;
  logic [SAMPLE_BITS-1:0]  top [TOP_DEPTH];
  logic                    rd_pend;
  logic [TIDX_W-1:0]       sidx;
  logic [ACC_W-1:0]        acc;
  logic [TOP_W-1:0]        cnt;
  logic [TOP_W:0]          rem;
  logic [ACC_W-1:0]        quo;
  logic [DSTP_W-1:0]       dstep;

  // store
  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_raddr;
  logic [SAMPLE_BITS-1:0]  ram_rdata;

  // effective pick count, clamped to 1..TOP_DEPTH
  logic [TOP_W-1:0] k_use;
  always_comb begin
    if (pick_count == 5'd0) begin
      k_use = TOP_W'(1);
    end else if (32'(pick_count) > TOP_DEPTH) begin
      k_use = TOP_W'(TOP_DEPTH);
    end else begin
      k_use = TOP_W'(pick_count);
    end
  end

  // item decode
  logic       above;
  logic [7:0] q_inc;
  logic       full;
  assign above = in_sample > threshold;
  assign q_inc = (quiet == 8'hFF) ? quiet : quiet + 8'd1;
  assign full  = fill >= PTR_W'(PULSE_DEPTH);

  assign status.res_now   = (cmd_t'(in_cmd) == CMD_READ) && (mode != MODE_FINISHED);
  assign status.res_read  = (cmd_t'(in_cmd) == CMD_READ) && (mode == MODE_FINISHED);
  assign status.fin       = (cmd_t'(in_cmd) == CMD_SAMPLE) && (mode == MODE_IDLE) &&
                            pulse_act && !above && (q_inc > quiet_limit);
  assign status.walk_done = (fill == '0) && !rd_pend;
  assign status.sum_last  = sidx == TIDX_W'(TOP_DEPTH - 1);
  assign status.div_last  = dstep == DSTP_W'(ACC_W - 1);

  // store write on sample words
  always_comb begin
    ram_we = 1'b0;
    if (cmd.step && cmd_t'(in_cmd) == CMD_SAMPLE) begin
      if (mode == MODE_CAPTURE) begin
        ram_we = 1'b1;
      end else if (mode == MODE_IDLE && above) begin
        ram_we = !pulse_act || !full;
      end
    end
  end

  logic [ADDR_W-1:0] waddr;
  assign waddr = (mode == MODE_IDLE && !pulse_act) ? '0 : fill[ADDR_W-1:0];

  assign ram_raddr = cmd.walk ? ADDR_W'(fill - PTR_W'(1)) : fill[ADDR_W-1:0];

  pktd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(PULSE_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (in_sample),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sorted insert into the descending top list, first k_use places
  logic [SAMPLE_BITS-1:0] top_ins [TOP_DEPTH];
  logic [TOP_DEPTH-1:0]   lt;
  always_comb begin
    for (int i = 0; i < TOP_DEPTH; i++) begin
      lt[i] = top[i] < ram_rdata;
    end
    for (int i = 0; i < TOP_DEPTH; i++) begin
      if (TOP_W'(i) >= k_use || !lt[i]) begin
        top_ins[i] = top[i];
      end else if (i == 0) begin
        top_ins[i] = ram_rdata;
      end else if (!lt[(i > 0) ? i - 1 : 0]) begin
        top_ins[i] = ram_rdata;
      end else begin
        top_ins[i] = top[(i > 0) ? i - 1 : 0];
      end
    end
  end

  // divider step
  logic [TOP_W:0]   div_r;
  logic             div_ge;
  logic [ACC_W-1:0] quo_next;
  assign div_r    = {rem[TOP_W-1:0], quo[ACC_W-1]};
  assign div_ge   = div_r >= {1'b0, cnt};
  assign quo_next = {quo[ACC_W-2:0], div_ge};

  // main state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      pulse_act <= 1'b0;
      fill      <= '0;
      quiet     <= '0;
      total     <= '0;
      rd_pend   <= 1'b0;
      for (int i = 0; i < TOP_DEPTH; i++) begin
        top[i] <= '0;
      end
    end else begin
      if (cmd.step) begin
        case (cmd_t'(in_cmd))
          CMD_START: begin
            pulse_act <= 1'b0;
            fill      <= '0;
            quiet     <= '0;
            mode      <= MODE_CAPTURE;
            for (int i = 0; i < TOP_DEPTH; i++) begin
              top[i] <= '0;
            end
          end
          CMD_ABORT: begin
            if (mode != MODE_IDLE) begin
              mode <= MODE_IDLE;
              fill <= '0;
            end
          end
          CMD_READ: begin
            if (mode == MODE_FINISHED) begin
              if (fill >= PTR_W'(PULSE_DEPTH - 1)) begin
                mode <= MODE_IDLE;
                fill <= '0;
              end else begin
                fill <= fill + PTR_W'(1);
              end
            end
          end
          default: begin
            if (mode == MODE_CAPTURE) begin
              if (fill == PTR_W'(PULSE_DEPTH - 1)) begin
                mode <= MODE_FINISHED;
                fill <= '0;
              end else begin
                fill <= fill + PTR_W'(1);
              end
            end else if (mode == MODE_IDLE) begin
              if (!pulse_act) begin
                if (above) begin
                  pulse_act <= 1'b1;
                  quiet     <= '0;
                  fill      <= PTR_W'(1);
                end
              end else if (above) begin
                quiet <= '0;
                if (full) begin
                  fill      <= '0;
                  pulse_act <= 1'b0;
                end else begin
                  fill <= fill + PTR_W'(1);
                end
              end else if (q_inc > quiet_limit) begin
                // pulse over: count it, list gets built by the walk
                quiet     <= '0;
                pulse_act <= 1'b0;
                total     <= total + 32'd1;
              end else begin
                quiet <= q_inc;
              end
            end
          end
        endcase
      end

      // walk the buffered pulse from the end
      if (cmd.walk) begin
        if (fill != '0) begin
          fill    <= fill - PTR_W'(1);
          rd_pend <= 1'b1;
        end else begin
          rd_pend <= 1'b0;
        end
        if (rd_pend) begin
          top <= top_ins;
        end
      end

      // drain the list; it is left cleared
      if (cmd.sum) begin
        for (int i = 0; i < TOP_DEPTH - 1; i++) begin
          top[i] <= top[i + 1];
        end
        top[TOP_DEPTH - 1] <= '0;
      end
    end
  end

  // sum, count and divide
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      acc  <= '0;
      cnt  <= '0;
      sidx <= '0;
    end
    if (cmd.sum) begin
      sidx <= sidx + TIDX_W'(1);
      if (top[0] != '0) begin
        acc <= acc + ACC_W'(top[0]);
        cnt <= cnt + TOP_W'(1);
      end
    end
    if (cmd.div_init) begin
      rem   <= '0;
      quo   <= acc;
      dstep <= '0;
    end
    if (cmd.div_step) begin
      rem   <= div_ge ? div_r - {1'b0, cnt} : div_r;
      quo   <= quo_next;
      dstep <= dstep + DSTP_W'(1);
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      if (cmd_t'(in_cmd) == CMD_READ) begin
        kind           <= KIND_READ;
        energy         <= '0;
        pulse_total    <= '0;
        entry_index    <= (mode == MODE_FINISHED) ? 8'(fill) : 8'd0;
        capture_status <= mode;
      end else begin
        kind           <= KIND_PULSE;
        pulse_total    <= total + 32'd1;
        entry_index    <= '0;
        capture_status <= MODE_IDLE;
      end
    end
    if (cmd.ld_read) begin
      energy <= ram_rdata;
    end
    if (cmd.div_step && status.div_last) begin
      energy <= (cnt == '0) ? 12'd0 : quo_next[SAMPLE_BITS-1:0];
    end
  end

endmodule

// ===== rtl/core/pktd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pktd_ctrl
// Sequencer: item steps, capture reads and the pulse-end walk/sum/divide.
// ----------------------------------------------------------------------------
module pktd_ctrl import pktd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDWAIT,
    S_WALK,
    S_SUM,
    S_DINIT,
    S_DIV
  } state_t;

  state_t state;
  logic   accept;

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign accept   = in_valid && in_ready;

  // commands
  always_comb begin
    cmd          = '0;
    cmd.step     = accept;
    cmd.ld_read  = state == S_RDWAIT;
    cmd.walk     = state == S_WALK;
    cmd.sum      = state == S_SUM;
    cmd.div_init = state == S_DINIT;
    cmd.div_step = state == S_DIV;
  end

  // state and output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (status.res_now) begin
              out_valid <= 1'b1;
            end else if (status.res_read) begin
              state <= S_RDWAIT;
            end else if (status.fin) begin
              state <= S_WALK;
            end
          end
        end
        S_RDWAIT: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        S_WALK: begin
          if (status.walk_done) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          if (status.sum_last) begin
            state <= S_DINIT;
          end
        end
        S_DINIT: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (status.div_last) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_read_answers: assert property (@(posedge clk) disable iff (rst)
    state == S_RDWAIT |=> out_valid)
    else $error("capture read gave no result word");

  a_fin_walks: assert property (@(posedge clk) disable iff (rst)
    accept && status.fin |=> state == S_WALK)
    else $error("pulse end did not start the walk");

  a_valid_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_IDLE)
    else $error("result word pending while busy");

endmodule
